// ===== sv/gta_pkg.sv =====
// Shared constants, codes and control types for the greedy tile assigner.
// No dependencies; every other file of the block imports this package.
package gta_pkg;

  // Sizing of the block
  localparam int MAX_GRID_SIDE = 64;
  localparam int MAX_RADIUS    = 8;
  localparam int TILE_ID_BITS  = 16;

  // Fixed field widths of the channels and registers
  localparam int OP_W       = 2;
  localparam int POS_W      = 6;
  localparam int TILE_W     = 16;
  localparam int DIST_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int COST_W     = 48;
  localparam int SIDE_W     = 7;
  localparam int RADIUS_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Register reset values
  localparam int GRID_WIDTH_RST  = 64;
  localparam int GRID_HEIGHT_RST = 64;
  localparam int RADIUS_RST      = 4;

  // Derived widths
  localparam int CELLS   = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int MEM_W   = TILE_ID_BITS + 1;
  localparam int GS_W    = $clog2(MAX_GRID_SIDE + 1);
  localparam int SCMP_W  = (SIDE_W > GS_W) ? SIDE_W : GS_W;
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int RCMP_W  = (RADIUS_W > RAD_W) ? RADIUS_W : RAD_W;
  localparam int OFF_W   = $clog2(MAX_RADIUS) + 1;
  localparam int COORD_W = ((POS_W > SCMP_W) ? POS_W : SCMP_W) + OFF_W + 1;
  localparam int D2_W    = 2 * OFF_W + 1;
  localparam int LIM_W   = 2 * RAD_W;

  typedef enum logic [OP_W-1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } gta_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_ACCEPTED = 3'd0,
    STS_TAKEN    = 3'd1,
    STS_CONFLICT = 3'd2,
    STS_DONE     = 3'd3,
    STS_BAD_POS  = 3'd4
  } gta_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_RADIUS      = 2'd2
  } gta_cfg_idx_t;

  // Where the reported cell contents come from
  typedef enum logic [1:0] {
    RES_EMPTY   = 2'd0,
    RES_STORED  = 2'd1,
    RES_OFFERED = 2'd2
  } gta_res_src_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_REPLY
  } gta_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         load_item;
    logic         sweep_write;
    logic         cost_clear;
    logic         scan_init;
    logic         scan_step;
    logic         commit;
    logic         res_set;
    gta_status_t  res_status;
    gta_res_src_t res_src;
    logic         load_out;
  } gta_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_bounds;
    logic            center_taken;
    logic            rad_zero;
    logic            scan_last;
    logic            sweep_last;
    logic            conflict;
    logic            out_free;
  } gta_stat_t;

endpackage

// ===== sv/gta_in_if.sv =====
// Input channel of the tile assigner: valid/ready plus one operation item.
// Depends on gta_pkg for field widths.
interface gta_in_if;
  import gta_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    row;
  logic [POS_W-1:0]    col;
  logic [TILE_W-1:0]   tile_id;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, operation, row, col, tile_id, distance, input ready);
  modport sink   (input valid, operation, row, col, tile_id, distance, output ready);
endinterface

// ===== sv/gta_out_if.sv =====
// Result channel of the tile assigner: valid/ready plus one result item.
// Depends on gta_pkg for field widths.
interface gta_out_if;
  import gta_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                cell_valid;
  logic [TILE_W-1:0]   cell_tile;
  logic [COST_W-1:0]   total_cost;

  modport source (output valid, status, cell_valid, cell_tile, total_cost, input ready);
  modport sink   (input valid, status, cell_valid, cell_tile, total_cost, output ready);
endinterface

// ===== sv/gta_cfg_if.sv =====
// Configuration write channel of the tile assigner: register index and data.
// Depends on gta_pkg for field widths.
interface gta_cfg_if;
  import gta_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/gta_dp.sv =====
// Datapath of the tile assigner: config registers, item registers, grid memory,
// neighbor scan counters, cost accumulator and the output register. Uses gta_pkg.
module gta_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gta_pkg::gta_cmd_t              cmd,
  output gta_pkg::gta_stat_t             stat,
  input  logic [gta_pkg::OP_W-1:0]       in_operation,
  input  logic [gta_pkg::POS_W-1:0]      in_row,
  input  logic [gta_pkg::POS_W-1:0]      in_col,
  input  logic [gta_pkg::TILE_W-1:0]     in_tile_id,
  input  logic [gta_pkg::DIST_W-1:0]     in_distance,
  input  logic                           cfg_valid,
  input  logic [gta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gta_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [gta_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_cell_valid,
  output logic [gta_pkg::TILE_W-1:0]     out_cell_tile,
  output logic [gta_pkg::COST_W-1:0]     out_total_cost
);
  import gta_pkg::*;

  logic [SIDE_W-1:0]        grid_w_r;
  logic [SIDE_W-1:0]        grid_h_r;
  logic [RADIUS_W-1:0]      radius_r;
  logic [SCMP_W-1:0]        w_c;
  logic [SCMP_W-1:0]        h_c;
  logic [RAD_W-1:0]         rad_c;

  logic [OP_W-1:0]          op_r;
  logic [POS_W-1:0]         row_r;
  logic [POS_W-1:0]         col_r;
  logic [TILE_ID_BITS-1:0]  tile_r;
  logic [DIST_W-1:0]        dist_r;

  logic signed [OFF_W-1:0]  dr_r;
  logic signed [OFF_W-1:0]  dc_r;
  logic [OFF_W-1:0]         off_first;
  logic [OFF_W-1:0]         off_last;
  logic signed [COORD_W-1:0] nr;
  logic signed [COORD_W-1:0] nc;
  logic signed [2*OFF_W-1:0] dr_x;
  logic signed [2*OFF_W-1:0] dc_x;
  logic [2*OFF_W-1:0]       dr_sq;
  logic [2*OFF_W-1:0]       dc_sq;
  logic [D2_W-1:0]          d2;
  logic [LIM_W-1:0]         rad_x;
  logic [LIM_W-1:0]         lim;
  logic                     nr_in;
  logic                     nc_in;
  logic                     qual;
  logic                     chk_r;
  logic                     hit;
  logic                     conflict_r;

  logic [CELL_W-1:0]        ctr_addr;
  logic [CELL_W-1:0]        nb_addr;
  logic [CELL_W-1:0]        sweep_addr_r;
  logic [CELL_W-1:0]        wr_addr;
  logic [CELL_W-1:0]        rd_addr;
  logic [MEM_W-1:0]         wr_data;
  logic                     mem_we;
  logic [MEM_W-1:0]         mem [CELLS];
  logic [MEM_W-1:0]         rd_data_r;

  logic [COST_W-1:0]        cost_r;
  logic [COST_W:0]          cost_sum;

  gta_status_t              res_status_r;
  logic                     res_valid_r;
  logic [TILE_ID_BITS-1:0]  res_tile_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_cell_valid_r;
  logic [TILE_W-1:0]        out_cell_tile_r;
  logic [COST_W-1:0]        out_total_cost_r;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= SIDE_W'(GRID_WIDTH_RST);
      grid_h_r <= SIDE_W'(GRID_HEIGHT_RST);
      radius_r <= RADIUS_W'(RADIUS_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_w_r <= cfg_data[SIDE_W-1:0];
        CFG_GRID_HEIGHT: grid_h_r <= cfg_data[SIDE_W-1:0];
        CFG_RADIUS:      radius_r <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size and radius to the supported maximum
  assign w_c = (SCMP_W'(grid_w_r) > SCMP_W'(MAX_GRID_SIDE)) ?
               SCMP_W'(MAX_GRID_SIDE) : SCMP_W'(grid_w_r);
  assign h_c = (SCMP_W'(grid_h_r) > SCMP_W'(MAX_GRID_SIDE)) ?
               SCMP_W'(MAX_GRID_SIDE) : SCMP_W'(grid_h_r);
  assign rad_c = (RCMP_W'(radius_r) > RCMP_W'(MAX_RADIUS)) ?
                 RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_operation;
      row_r  <= in_row;
      col_r  <= in_col;
      tile_r <= TILE_ID_BITS'(in_tile_id);
      dist_r <= in_distance;
    end
  end

  assign ctr_addr = CELL_W'(CELL_W'(row_r) * CELL_W'(MAX_GRID_SIDE)) + CELL_W'(col_r);

  // Walk the square of offsets row by row
  assign off_last  = OFF_W'(rad_c) - OFF_W'(1);
  assign off_first = OFF_W'(1) - OFF_W'(rad_c);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      dr_r <= off_first;
      dc_r <= off_first;
    end else if (cmd.scan_step) begin
      if ($unsigned(dc_r) == off_last) begin
        dc_r <= off_first;
        dr_r <= dr_r + OFF_W'(1);
      end else begin
        dc_r <= dc_r + OFF_W'(1);
      end
    end
  end

  // Neighbor position and its distance test
  assign nr    = $signed(COORD_W'(row_r)) + COORD_W'(dr_r);
  assign nc    = $signed(COORD_W'(col_r)) + COORD_W'(dc_r);
  assign dr_x  = (2*OFF_W)'(dr_r);
  assign dc_x  = (2*OFF_W)'(dc_r);
  assign dr_sq = dr_x * dr_x;
  assign dc_sq = dc_x * dc_x;
  assign d2    = D2_W'(dr_sq) + D2_W'(dc_sq);
  assign rad_x = LIM_W'(rad_c);
  assign lim   = rad_x * rad_x - rad_x;
  assign nr_in = !nr[COORD_W-1] && ($unsigned(nr) < COORD_W'(h_c));
  assign nc_in = !nc[COORD_W-1] && ($unsigned(nc) < COORD_W'(w_c));
  assign qual  = (d2 != '0) && (d2 <= D2_W'(lim)) && nr_in && nc_in;
  assign nb_addr = CELL_W'(CELL_W'($unsigned(nr)) * CELL_W'(MAX_GRID_SIDE))
                   + CELL_W'($unsigned(nc));

  // Compare the neighbor read in the cycle after its address went out
  assign hit = chk_r && rd_data_r[MEM_W-1] && (rd_data_r[TILE_ID_BITS-1:0] == tile_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r      <= 1'b0;
      conflict_r <= 1'b0;
    end else begin
      chk_r <= cmd.scan_step && qual;
      if (cmd.load_item) begin
        conflict_r <= 1'b0;
      end else if (hit) begin
        conflict_r <= 1'b1;
      end
    end
  end

  // Advance the clearing sweep; it wraps back to zero after the last cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep_write) begin
      sweep_addr_r <= stat.sweep_last ? '0 : sweep_addr_r + CELL_W'(1);
    end
  end

  // Grid memory: valid bit over tile id, one write and one registered read
  assign mem_we  = cmd.sweep_write || cmd.commit;
  assign wr_addr = cmd.sweep_write ? sweep_addr_r : ctr_addr;
  assign wr_data = cmd.sweep_write ? '0 : {1'b1, tile_r};
  assign rd_addr = cmd.scan_step ? nb_addr : ctr_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Accumulate accepted distances, saturating at the top
  assign cost_sum = (COST_W+1)'(cost_r) + (COST_W+1)'(dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
    end else if (cmd.cost_clear) begin
      cost_r <= '0;
    end else if (cmd.commit) begin
      cost_r <= cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
    end
  end

  // Stage the result fields
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_src)
        RES_STORED: begin
          res_valid_r <= rd_data_r[MEM_W-1];
          res_tile_r  <= rd_data_r[MEM_W-1] ? rd_data_r[TILE_ID_BITS-1:0] : '0;
        end
        RES_OFFERED: begin
          res_valid_r <= 1'b1;
          res_tile_r  <= tile_r;
        end
        default: begin
          res_valid_r <= 1'b0;
          res_tile_r  <= '0;
        end
      endcase
    end
  end

  // Output register; holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r     <= res_status_r;
      out_cell_valid_r <= res_valid_r;
      out_cell_tile_r  <= TILE_W'(res_tile_r);
      out_total_cost_r <= cost_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cell_valid = out_cell_valid_r;
  assign out_cell_tile  = out_cell_tile_r;
  assign out_total_cost = out_total_cost_r;

  // Status back to the controller
  assign stat.op           = op_r;
  assign stat.in_bounds    = (SCMP_W'(row_r) < h_c) && (SCMP_W'(col_r) < w_c);
  assign stat.center_taken = rd_data_r[MEM_W-1];
  assign stat.rad_zero     = (rad_c == '0);
  assign stat.scan_last    = ($unsigned(dr_r) == off_last) && ($unsigned(dc_r) == off_last);
  assign stat.sweep_last   = (sweep_addr_r == CELL_W'(CELLS - 1));
  assign stat.conflict     = conflict_r;
  assign stat.out_free     = !out_valid_r || out_ready;

endmodule

// ===== sv/gta_ctrl.sv =====
// Controller of the tile assigner: sequences sweep, lookup, neighbor scan,
// commit and reply for each transaction. Uses gta_pkg command/status types.
module gta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gta_pkg::gta_stat_t stat,
  output gta_pkg::gta_cmd_t  cmd
);
  import gta_pkg::*;

  gta_state_t state_r;
  gta_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat.op == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if ((stat.op == OP_OFFER || stat.op == OP_READ) && stat.in_bounds) begin
          state_nxt = ST_CENTER;
        end else begin
          state_nxt = ST_REPLY;
        end
      end
      ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = ST_REPLY;
      end
      ST_CENTER: begin
        if (stat.op == OP_OFFER && !stat.center_taken) begin
          state_nxt = stat.rad_zero ? ST_DECIDE : ST_SCAN;
        end else begin
          state_nxt = ST_REPLY;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_REPLY;
      ST_REPLY: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT: cmd.sweep_write = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DISPATCH: begin
        if (stat.op == OP_OFFER || stat.op == OP_READ) begin
          if (!stat.in_bounds) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = STS_BAD_POS;
            cmd.res_src    = RES_EMPTY;
          end
        end else if (stat.op != OP_CLEAR) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = STS_DONE;
          cmd.res_src    = RES_EMPTY;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_write = 1'b1;
        if (stat.sweep_last) begin
          cmd.cost_clear = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = STS_DONE;
          cmd.res_src    = RES_EMPTY;
        end
      end
      ST_CENTER: begin
        if (stat.op == OP_OFFER && !stat.center_taken) begin
          cmd.scan_init = !stat.rad_zero;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = (stat.op == OP_READ) ? STS_DONE : STS_TAKEN;
          cmd.res_src    = RES_STORED;
        end
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DRAIN: ;
      ST_DECIDE: begin
        cmd.res_set = 1'b1;
        if (stat.conflict) begin
          cmd.res_status = STS_CONFLICT;
          cmd.res_src    = RES_EMPTY;
        end else begin
          cmd.commit     = 1'b1;
          cmd.res_status = STS_ACCEPTED;
          cmd.res_src    = RES_OFFERED;
        end
      end
      ST_REPLY: cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

  // Never overwrite a result the receiver has not taken
  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded while output register still full");

  // A commit never competes with a clearing write for the memory port
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !cmd.sweep_write)
    else $error("commit and sweep write in the same cycle");

  // The scan runs until its last offset
  a_scan_stay: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !stat.scan_last) |=> (state_r == ST_SCAN))
    else $error("neighbor scan left early");

  // Decisions follow a drained scan or a skipped scan
  a_decide_from: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |->
      ($past(state_r) == ST_DRAIN || $past(state_r) == ST_CENTER))
    else $error("decide reached without a completed scan");

endmodule

// ===== sv/greedy_tile_assign_exclusion.sv =====
// Top level of the greedy tile assigner with neighbor exclusion.
// Depends on gta_pkg, the three channel interfaces, gta_ctrl and gta_dp.
//
// Usage:
//   in_ch   takes one operation per transaction: offer (row, col, tile_id,
//           distance), read cell, or clear grid and cost.
//   out_ch  returns exactly one result per input transaction, in order.
//   cfg_ch  writes grid_width (0), grid_height (1) and radius (2); it is
//           always ready and must only be used while the block is idle.
// Work per operation:
//   read, taken cell, bad position or unused code: no neighbor scan.
//   offer: one grid memory read per neighbor offset of the (2*radius-1)^2
//           square, through the single read port.
//   offer with radius zero: no neighbor scan.
//   clear: one grid cell cleared per cycle, over all 4096 cells.
//   The next transaction is accepted from the cycle after the result is loaded.
// Reset: a clearing pass runs through all 4096 cells of the grid memory; in_ch
//   stays not ready until it ends, cfg_ch writes are taken meanwhile.
// Stall: the result sits in an output register; while it waits, the next
//   transaction is accepted and worked on, and its result waits for the slot.
module greedy_tile_assign_exclusion (
  input logic       clk,
  input logic       rst_n,
  gta_in_if.sink    in_ch,
  gta_out_if.source out_ch,
  gta_cfg_if.sink   cfg_ch
);
  import gta_pkg::*;

  gta_cmd_t  cmd;
  gta_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  gta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gta_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_ch.operation),
    .in_row         (in_ch.row),
    .in_col         (in_ch.col),
    .in_tile_id     (in_ch.tile_id),
    .in_distance    (in_ch.distance),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_cell_valid (out_ch.cell_valid),
    .out_cell_tile  (out_ch.cell_tile),
    .out_total_cost (out_ch.total_cost)
  );

endmodule
